FILE: src/tone_generator_with_fade_assert.svh
// assertion macros for the tone generator checks
`ifndef TONE_GENERATOR_WITH_FADE_ASSERT_SVH
`define TONE_GENERATOR_WITH_FADE_ASSERT_SVH

// same-cycle implication
`define TGF_ASSERT_IMP(label, ck, rn, cond, prop) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond) |-> (prop)) \
        else $error("tone generator check failed");

// next-cycle implication
`define TGF_ASSERT_NEXT(label, ck, rn, cond, prop) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (prop)) \
        else $error("tone generator check failed");

`endif

FILE: src/tgf_pkg.sv
// shared constants, types and sine table builder for the tone generator
`timescale 1ns / 1ps

package tgf_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int QUARTER          = SINE_TABLE_DEPTH / 4;
    localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);
    localparam int ROM_ADDR_W       = IDX_W - 1;
    localparam int SINE_W           = 15;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam int PHASE_W  = 32;
    localparam int LEN_W    = 20;
    localparam int FADE_W   = 16;
    localparam int RECIP_W  = 17;
    localparam int PEAK_W   = 15;
    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 21;
    localparam int ENV_W    = 17;
    localparam int MAG_W    = 16;
    localparam int ENV_PROD_W = RECIP_W + FADE_W;
    localparam int GAIN_SHIFT = 31;

    localparam logic [ENV_W-1:0] ENV_ONE    = 17'h10000;
    localparam logic [MAG_W-1:0] SQUARE_MAG = 16'h8000;

    localparam int DIGIT_W      = 4;
    localparam int MUL_DIGITS   = 5;
    localparam int MUL_A_W      = 31;
    localparam int MUL_B_W      = DIGIT_W * MUL_DIGITS;
    localparam int MUL_P_W      = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W    = $clog2(MUL_DIGITS + 1);
    localparam int PHASE_DIGITS = PHASE_W / DIGIT_W;
    localparam int PHASE_CNT_W  = $clog2(PHASE_DIGITS + 1);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TONE_LENGTH     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FADE_LENGTH     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FADE_RECIPROCAL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PEAK_LEVEL      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SQUARE_MODE     = 3'd5;

    typedef logic [SINE_W-1:0] sine_lut_t [0:QUARTER];

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
    } wave_t;

    typedef struct packed {
        logic clear;
        logic start;
    } phase_ctrl_t;

    // quarter-wave entry from a fixed-point taylor series
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          v;
        x    = (64'(k) * HALF_PI_Q30) / QUARTER;
        x2   = (x * x) >> 30;
        sum  = longint'(x);
        term = ((x * x2) >> 30) / 6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 156;
        sum  = sum + longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        v = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
        if (v > 32767)
        begin
            v = 32767;
        end
        return v[SINE_W-1:0];
    endfunction

    function automatic sine_lut_t build_sine_lut();
        sine_lut_t lut;
        for (int k = 0; k <= QUARTER; k++)
        begin
            lut[k] = sine_entry(k);
        end
        return lut;
    endfunction

endpackage

FILE: src/tone_generator_with_fade.sv
// Tone generator with linear fade: every request on the input stream yields one signed
// 16-bit sample of a sine or square tone from a 32-bit phase accumulator and a
// 257-entry quarter-wave table, scaled by the peak level and a linear fade envelope.
// A sample inside the tone goes through these steps to the output register: accept,
// table lookup and envelope selection, then three passes through one shared
// multiplier that consumes a 4-bit digit per cycle (envelope, peak level, envelope
// gain), then a load into the output register, held while the output is stalled.
// A request after the tone has ended skips the multiplier passes. The phase advances
// a digit per cycle in the background. A new request is taken while the previous
// result still waits in the output register.
`timescale 1ns / 1ps
`include "tone_generator_with_fade_assert.svh"

module tone_generator_with_fade (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // [0] restart
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [tgf_pkg::SAMPLE_W-1:0]       m_axis_tdata,  // [15:0] sample
    output logic                               m_axis_tlast,
    output logic                               m_axis_tuser,  // [0] finished
    input  logic                               cfg_wen,
    input  logic [tgf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tgf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tgf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_ENV  = 3'd2;
    localparam logic [2:0] S_AMP  = 3'd3;
    localparam logic [2:0] S_GAIN = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]          state_reg, state_next;

    logic [PHASE_W-1:0]  phase_step_reg;
    logic [LEN_W-1:0]    tone_length_reg;
    logic [FADE_W-1:0]   fade_length_reg;
    logic [RECIP_W-1:0]  fade_reciprocal_reg;
    logic [PEAK_W-1:0]   peak_level_reg;
    logic                square_mode_reg;

    logic [INDEX_W-1:0]  index_reg, index_next;
    logic                ramp_reg, ramp_next;
    logic [ENV_W-1:0]    env_reg, env_next;
    logic [SAMPLE_W-1:0] res_sample_reg, res_sample_next;
    logic                res_last_reg, res_last_next;
    logic                res_fin_reg, res_fin_next;

    logic                m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0] out_sample_reg;
    logic                out_last_reg;
    logic                out_fin_reg;
    logic                out_load;

    phase_ctrl_t         pctrl;
    logic [PHASE_W-1:0]  phase;
    logic                wave_load;
    wave_t               wave;

    logic                mul_start;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic                mul_done;
    logic [MUL_P_W-1:0]  mul_prod;

    logic [INDEX_W-1:0]  tone_len_ext;
    logic [INDEX_W-1:0]  fade_len_ext;
    logic [INDEX_W-1:0]  tail_start;
    logic [INDEX_W-1:0]  to_end;
    logic                fin;
    logic                last;
    logic                fade_on;
    logic                rise;
    logic                fall;
    logic                ramp;
    logic [FADE_W-1:0]   ramp_pos;
    logic [SAMPLE_W-1:0] gain_mag;

    tgf_phase_acc u_phase (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (pctrl),
        .step  (phase_step_reg),
        .phase (phase)
    );

    tgf_wave u_wave (
        .clk         (clk),
        .load        (wave_load),
        .phase_idx   (phase[PHASE_W-1 -: IDX_W]),
        .square_mode (square_mode_reg),
        .wave        (wave)
    );

    tgf_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    // position within the tone
    assign tone_len_ext = INDEX_W'(tone_length_reg);
    assign fade_len_ext = INDEX_W'(fade_length_reg);
    assign tail_start   = tone_len_ext - fade_len_ext;
    assign to_end       = tone_len_ext - index_reg;
    assign fin          = (index_reg >= tone_len_ext);
    assign last         = (index_reg == tone_len_ext - INDEX_W'(1));
    assign fade_on      = (fade_length_reg != '0)
                       && (tone_length_reg > {3'b000, fade_length_reg, 1'b0});
    assign rise         = (index_reg < fade_len_ext);
    assign fall         = (index_reg >= tail_start);
    assign ramp         = fade_on && (rise || fall);
    assign ramp_pos     = rise ? index_reg[FADE_W-1:0] : to_end[FADE_W-1:0];
    assign gain_mag     = mul_prod[GAIN_SHIFT +: SAMPLE_W];

    always_comb
    begin
        state_next      = state_reg;
        index_next      = index_reg;
        ramp_next       = ramp_reg;
        env_next        = env_reg;
        res_sample_next = res_sample_reg;
        res_last_next   = res_last_reg;
        res_fin_next    = res_fin_reg;
        pctrl           = '0;
        wave_load       = 1'b0;
        mul_start       = 1'b0;
        mul_a           = '0;
        mul_b           = '0;
        out_load        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tdata[0])
                    begin
                        pctrl.clear = 1'b1;
                        index_next  = '0;
                    end
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                wave_load       = 1'b1;
                res_fin_next    = fin;
                res_last_next   = !fin && last;
                res_sample_next = '0;
                ramp_next       = ramp;
                if (fin)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    mul_start   = 1'b1;
                    mul_a       = MUL_A_W'(fade_reciprocal_reg);
                    mul_b       = ramp ? MUL_B_W'(ramp_pos) : '0;
                    pctrl.start = 1'b1;
                    index_next  = index_reg + INDEX_W'(1);
                    state_next  = S_ENV;
                end
            end
            S_ENV:
            begin
                if (mul_done)
                begin
                    if (!ramp_reg)
                    begin
                        env_next = ENV_ONE;
                    end
                    else if (mul_prod[ENV_PROD_W-1:0] > ENV_PROD_W'(ENV_ONE))
                    begin
                        env_next = ENV_ONE;
                    end
                    else
                    begin
                        env_next = mul_prod[ENV_W-1:0];
                    end
                    mul_start  = 1'b1;
                    mul_a      = MUL_A_W'(wave.mag);
                    mul_b      = MUL_B_W'(peak_level_reg);
                    state_next = S_AMP;
                end
            end
            S_AMP:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = mul_prod[MUL_A_W-1:0];
                    mul_b      = MUL_B_W'(env_reg);
                    state_next = S_GAIN;
                end
            end
            S_GAIN:
            begin
                if (mul_done)
                begin
                    res_sample_next = wave.neg ? (SAMPLE_W'(0) - gain_mag) : gain_mag;
                    state_next      = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            index_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            index_reg   <= index_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ramp_reg       <= ramp_next;
        env_reg        <= env_next;
        res_sample_reg <= res_sample_next;
        res_last_reg   <= res_last_next;
        res_fin_reg    <= res_fin_next;
        if (out_load)
        begin
            out_sample_reg <= res_sample_reg;
            out_last_reg   <= res_last_reg;
            out_fin_reg    <= res_fin_reg;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg      <= '0;
            tone_length_reg     <= '0;
            fade_length_reg     <= FADE_W'(352);
            fade_reciprocal_reg <= RECIP_W'(186);
            peak_level_reg      <= PEAK_W'(16000);
            square_mode_reg     <= 1'b0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_PHASE_STEP:      phase_step_reg      <= cfg_data[PHASE_W-1:0];
                REG_TONE_LENGTH:     tone_length_reg     <= cfg_data[LEN_W-1:0];
                REG_FADE_LENGTH:     fade_length_reg     <= cfg_data[FADE_W-1:0];
                REG_FADE_RECIPROCAL: fade_reciprocal_reg <= cfg_data[RECIP_W-1:0];
                REG_PEAK_LEVEL:      peak_level_reg      <= cfg_data[PEAK_W-1:0];
                REG_SQUARE_MODE:     square_mode_reg     <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_sample_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_fin_reg;

    `TGF_ASSERT_IMP(a_finished_is_silent, clk, rst_n, m_axis_tvalid && m_axis_tuser, (m_axis_tdata == '0) && !m_axis_tlast)
    `TGF_ASSERT_NEXT(a_one_request_at_a_time, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `TGF_ASSERT_IMP(a_mul_done_in_pass, clk, rst_n, mul_done, (state_reg == S_ENV) || (state_reg == S_AMP) || (state_reg == S_GAIN))
    `TGF_ASSERT_IMP(a_sample_in_range, clk, rst_n, m_axis_tvalid, m_axis_tdata != 16'h8000)

endmodule

FILE: src/tgf_phase_acc.sv
// phase accumulator advanced one 4-bit digit per cycle
`timescale 1ns / 1ps

module tgf_phase_acc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tgf_pkg::phase_ctrl_t          ctrl,
    input  logic [tgf_pkg::PHASE_W-1:0]   step,
    output logic [tgf_pkg::PHASE_W-1:0]   phase
);
    import tgf_pkg::*;

    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic [PHASE_W-1:0]     step_sr_reg, step_sr_next;
    logic                   carry_reg, carry_next;
    logic [PHASE_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIGIT_W:0]       digit_sum;

    assign digit_sum = {1'b0, phase_reg[DIGIT_W-1:0]} + {1'b0, step_sr_reg[DIGIT_W-1:0]}
                     + (DIGIT_W + 1)'(carry_reg);

    always_comb
    begin
        phase_next   = phase_reg;
        step_sr_next = step_sr_reg;
        carry_next   = carry_reg;
        cnt_next     = cnt_reg;
        if (ctrl.clear)
        begin
            phase_next = '0;
            cnt_next   = '0;
        end
        else if (ctrl.start)
        begin
            step_sr_next = step;
            carry_next   = 1'b0;
            cnt_next     = PHASE_CNT_W'(PHASE_DIGITS);
        end
        else if (cnt_reg != '0)
        begin
            // rotate right, new digit enters at the top
            phase_next   = {digit_sum[DIGIT_W-1:0], phase_reg[PHASE_W-1:DIGIT_W]};
            step_sr_next = step_sr_reg >> DIGIT_W;
            carry_next   = digit_sum[DIGIT_W];
            cnt_next     = cnt_reg - PHASE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            carry_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_sr_reg <= step_sr_next;
    end

    assign phase = phase_reg;

endmodule

FILE: src/tgf_wave.sv
// quarter-wave sine rom with quadrant folding and square mode
`timescale 1ns / 1ps

module tgf_wave (
    input  logic                        clk,
    input  logic                        load,
    input  logic [tgf_pkg::IDX_W-1:0]   phase_idx,
    input  logic                        square_mode,
    output tgf_pkg::wave_t              wave
);
    import tgf_pkg::*;

    localparam sine_lut_t SINE_LUT = build_sine_lut();

    logic [ROM_ADDR_W-1:0] addr_reg, addr_next;
    logic                  negq_reg;
    logic                  negq_d_reg;
    logic [SINE_W-1:0]     lut_data_reg;
    logic [IDX_W-3:0]      r;

    assign r = phase_idx[IDX_W-3:0];

    always_comb
    begin
        if (phase_idx[IDX_W-2])
        begin
            addr_next = ROM_ADDR_W'(QUARTER) - {1'b0, r};
        end
        else
        begin
            addr_next = {1'b0, r};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addr_reg <= addr_next;
            negq_reg <= phase_idx[IDX_W-1];
        end
        lut_data_reg <= SINE_LUT[addr_reg];
        negq_d_reg   <= negq_reg;
    end

    // a zero entry counts as positive
    assign wave.neg = negq_d_reg && (lut_data_reg != '0);
    assign wave.mag = square_mode ? SQUARE_MAG : {1'b0, lut_data_reg};

endmodule

FILE: src/tgf_serial_mul.sv
// shift-add multiplier taking one 4-bit digit of the multiplier per cycle
`timescale 1ns / 1ps

module tgf_serial_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tgf_pkg::MUL_A_W-1:0]   a,
    input  logic [tgf_pkg::MUL_B_W-1:0]   b,
    output logic                          done,
    output logic [tgf_pkg::MUL_P_W-1:0]   product
);
    import tgf_pkg::*;

    localparam int SUM_W = MUL_A_W + DIGIT_W;

    logic [MUL_A_W-1:0]   a_reg, a_next;
    logic [MUL_B_W-1:0]   b_reg, b_next;
    logic [MUL_A_W-1:0]   hi_reg, hi_next;
    logic [MUL_B_W-1:0]   lo_reg, lo_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [SUM_W-1:0]     sum;

    assign sum = SUM_W'(hi_reg) + SUM_W'(a_reg) * SUM_W'(b_reg[DIGIT_W-1:0]);

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next   = a;
            b_next   = b;
            hi_next  = '0;
            lo_next  = '0;
            cnt_next = MUL_CNT_W'(MUL_DIGITS);
        end
        else if (cnt_reg != '0)
        begin
            hi_next   = sum[SUM_W-1:DIGIT_W];
            lo_next   = {sum[DIGIT_W-1:0], lo_reg[MUL_B_W-1:DIGIT_W]};
            b_next    = b_reg >> DIGIT_W;
            cnt_next  = cnt_reg - MUL_CNT_W'(1);
            done_next = (cnt_reg == MUL_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule
